/* rtl/core/srt_pkg.sv */
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the segment range translator
// Holds the default sizes, the field width of the ports and the command
// group that steers the sort chain.
// ----------------------------------------------------------------------------
`default_nettype none
package srt_pkg;

   localparam int DEF_TABLE_ENTRIES = 16;
   localparam int DEF_ADDR_BITS     = 32;
   localparam int FIELD_BITS        = 32;
   localparam int INDEX_BITS        = 4;
   localparam int ACTIVE_BITS       = 5;

   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   // command to every cell of the sort chain
   typedef struct packed {
      logic clear;
      logic insert;
      logic pop;
   } sort_cmd_type;

endpackage
`default_nettype wire

/* rtl/core/segment_range_translator.sv */
// ----------------------------------------------------------------------------
// segment_range_translator: address range remap through a segment table
// Loads remap segments and splits a translate range into mapped pieces and
// uncovered gaps.
// ----------------------------------------------------------------------------
// A load item is taken and busy never rises for it. A translate item keeps
// busy high while it reads each active table entry, while each covered span
// leaves the sort chain, then for the trailing gap and a final flush.
// Pieces appear one per strobe, mapped pieces first in table order, then
// gaps in ascending order; the receiver cannot stall, so every strobe
// must be taken in the cycle it is shown. An inverted range yields no piece.
// A piece is held back until the next piece is found or the range is flushed,
// so its last flag is known.
// ----------------------------------------------------------------------------
`default_nettype none
module segment_range_translator #(
   parameter int TABLE_ENTRIES = srt_pkg::DEF_TABLE_ENTRIES,
   parameter int ADDR_BITS     = srt_pkg::DEF_ADDR_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_op,
   input  wire logic [srt_pkg::INDEX_BITS-1:0]    req_entry_index,
   input  wire logic [srt_pkg::FIELD_BITS-1:0]    req_source_base,
   input  wire logic [srt_pkg::FIELD_BITS-1:0]    req_target_base,
   input  wire logic [srt_pkg::FIELD_BITS-1:0]    req_region_length,
   input  wire logic [srt_pkg::FIELD_BITS-1:0]    req_range_start,
   input  wire logic [srt_pkg::FIELD_BITS-1:0]    req_range_end,
   output logic                                   rsp_strobe,
   output logic      [srt_pkg::FIELD_BITS-1:0]    rsp_piece_start,
   output logic      [srt_pkg::FIELD_BITS-1:0]    rsp_piece_end,
   output logic                                   rsp_piece_mapped,
   output logic                                   rsp_last_piece,
   input  wire logic                              csr_write_enable,
   input  wire logic [srt_pkg::ACTIVE_BITS-1:0]   csr_write_data
);
   import srt_pkg::*;

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int AW = ADDR_BITS;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_TAIL  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [ACTIVE_BITS-1:0] active_ff;
   logic [CW-1:0]          idx_ff, idx_in;
   logic                   rd_v_ff, rd_v_in;
   logic [AW-1:0]          rs_ff, re_ff;
   logic [AW:0]            look_ff, look_in;

   logic                   accept, is_load, is_xlate;
   logic [AW-1:0]          in_src, in_tgt, in_len, in_rs, in_re;
   logic [ACTIVE_BITS:0]   count_lim;
   logic                   more_reads;

   logic [AW-1:0]          rd_start, rd_end, rd_offset;
   logic                   rd_nonzero;

   logic                   overlap;
   logic [AW-1:0]          ov_s, ov_e;

   sort_cmd_type           cmd;
   logic                   cell_shift [TABLE_ENTRIES];
   logic                   cell_v     [TABLE_ENTRIES];
   logic [AW-1:0]          cell_lo    [TABLE_ENTRIES];
   logic [AW-1:0]          cell_hi    [TABLE_ENTRIES];

   logic [AW:0]            head_lo_x, head_hi_p1;

   logic                   emit_v, emit_m;
   logic [AW-1:0]          emit_s, emit_e;
   logic                   pend_v_ff, pend_v_in;
   logic                   pend_m_ff;
   logic [AW-1:0]          pend_s_ff, pend_e_ff;
   logic                   out_v_ff, out_v_in, out_last_ff, out_last_in;
   logic                   out_m_ff;
   logic [AW-1:0]          out_s_ff, out_e_ff;

   // input transfer decode
   assign accept   = start && !busy;
   assign is_load  = accept && (req_op == OP_LOAD);
   assign is_xlate = accept && (req_op == OP_TRANSLATE);
   assign in_src   = AW'(req_source_base);
   assign in_tgt   = AW'(req_target_base);
   assign in_len   = AW'(req_region_length);
   assign in_rs    = AW'(req_range_start);
   assign in_re    = AW'(req_range_end);
   assign busy     = (state_ff != ST_IDLE);

   // active count, saturated at the table size
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_write_enable) begin
         active_ff <= csr_write_data;
      end
   end

   assign count_lim  = ({1'b0, active_ff} > (ACTIVE_BITS+1)'(TABLE_ENTRIES)) ?
                       (ACTIVE_BITS+1)'(TABLE_ENTRIES) : {1'b0, active_ff};
   assign more_reads = ((ACTIVE_BITS+1)'(idx_ff) < count_lim);

   srt_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDR_BITS     (AW),
      .IW            (IW)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (is_load),
      .wr_idx     (req_entry_index),
      .wr_source  (in_src),
      .wr_target  (in_tgt),
      .wr_length  (in_len),
      .rd_en      (state_ff == ST_SCAN),
      .rd_idx     (idx_ff[IW-1:0]),
      .rd_start   (rd_start),
      .rd_end     (rd_end),
      .rd_offset  (rd_offset),
      .rd_nonzero (rd_nonzero)
   );

   // overlap of the entry just read with the range
   assign overlap = rd_v_ff && rd_nonzero && !(re_ff < rd_start) && !(rs_ff > rd_end);
   assign ov_s    = (rs_ff > rd_start) ? rs_ff : rd_start;
   assign ov_e    = (re_ff < rd_end)   ? re_ff : rd_end;

   // sort chain commands
   always_comb begin
      cmd.clear  = is_xlate;
      cmd.insert = overlap;
      cmd.pop    = (state_ff == ST_DRAIN) && cell_v[0];
   end

   // chain of sort cells, head at index zero
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      logic          l_shift, l_v, r_v;
      logic [AW-1:0] l_lo, l_hi, r_lo, r_hi;
      if (g == 0) begin : g_first
         assign l_shift = 1'b0;
         assign l_v     = 1'b0;
         assign l_lo    = '0;
         assign l_hi    = '0;
      end else begin : g_mid
         assign l_shift = cell_shift[g-1];
         assign l_v     = cell_v[g-1];
         assign l_lo    = cell_lo[g-1];
         assign l_hi    = cell_hi[g-1];
      end
      if (g == TABLE_ENTRIES - 1) begin : g_last
         assign r_v  = 1'b0;
         assign r_lo = '0;
         assign r_hi = '0;
      end else begin : g_inner
         assign r_v  = cell_v[g+1];
         assign r_lo = cell_lo[g+1];
         assign r_hi = cell_hi[g+1];
      end
      srt_sort_cell #(.ADDR_BITS(AW)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key_lo      (ov_s),
         .key_hi      (ov_e),
         .left_shift  (l_shift),
         .left_valid  (l_v),
         .left_lo     (l_lo),
         .left_hi     (l_hi),
         .right_valid (r_v),
         .right_lo    (r_lo),
         .right_hi    (r_hi),
         .shift       (cell_shift[g]),
         .valid       (cell_v[g]),
         .lo          (cell_lo[g]),
         .hi          (cell_hi[g])
      );
   end

   assign head_lo_x  = {1'b0, cell_lo[0]};
   assign head_hi_p1 = {1'b0, cell_hi[0]} + (AW+1)'(1);

   // sequencer and piece selection
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rd_v_in  = 1'b0;
      look_in  = look_ff;
      emit_v   = 1'b0;
      emit_m   = 1'b0;
      emit_s   = '0;
      emit_e   = '0;
      if (overlap) begin
         emit_v = 1'b1;
         emit_m = 1'b1;
         emit_s = rd_offset + ov_s;
         emit_e = rd_offset + ov_e;
      end
      case (state_ff)
         ST_IDLE: begin
            if (is_xlate && !(in_rs > in_re)) begin
               state_in = ST_SCAN;
               idx_in   = '0;
               look_in  = {1'b0, in_rs};
            end
         end
         ST_SCAN: begin
            if (more_reads) begin
               rd_v_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cell_v[0]) begin
               if (head_lo_x > look_ff) begin
                  emit_v = 1'b1;
                  emit_s = look_ff[AW-1:0];
                  emit_e = cell_lo[0] - AW'(1);
               end
               if (head_hi_p1 > look_ff) begin
                  look_in = head_hi_p1;
               end
            end else begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (look_ff <= {1'b0, re_ff}) begin
               emit_v = 1'b1;
               emit_s = look_ff[AW-1:0];
               emit_e = re_ff;
            end
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold one piece back so the final one can carry its flag
   always_comb begin
      pend_v_in   = pend_v_ff;
      out_v_in    = 1'b0;
      out_last_in = 1'b0;
      if (emit_v) begin
         pend_v_in = 1'b1;
         out_v_in  = pend_v_ff;
      end else if (state_ff == ST_FLUSH) begin
         pend_v_in   = 1'b0;
         out_v_in    = pend_v_ff;
         out_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         rd_v_ff     <= 1'b0;
         pend_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
         out_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         rd_v_ff     <= rd_v_in;
         pend_v_ff   <= pend_v_in;
         out_v_ff    <= out_v_in;
         out_last_ff <= out_last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      look_ff <= look_in;
      if (is_xlate) begin
         rs_ff <= in_rs;
         re_ff <= in_re;
      end
      if (out_v_in) begin
         out_s_ff <= pend_s_ff;
         out_e_ff <= pend_e_ff;
         out_m_ff <= pend_m_ff;
      end
      if (emit_v) begin
         pend_s_ff <= emit_s;
         pend_e_ff <= emit_e;
         pend_m_ff <= emit_m;
      end
   end

   assign rsp_strobe       = out_v_ff;
   assign rsp_piece_start  = FIELD_BITS'(out_s_ff);
   assign rsp_piece_end    = FIELD_BITS'(out_e_ff);
   assign rsp_piece_mapped = out_m_ff;
   assign rsp_last_piece   = out_last_ff;

   // pieces transfer only while a range is in work or just after
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("piece strobe without a range in work");

   // a last piece ends the range
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_piece) |-> !busy)
      else $error("last piece while still busy");

   // the chain never overflows on insert
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !cell_v[TABLE_ENTRIES-1])
      else $error("sort chain overflow");

   // a finished range leaves nothing held back
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |=> !pend_v_ff)
      else $error("piece left pending after flush");

endmodule
`default_nettype wire

/* rtl/core/srt_table.sv */
// ----------------------------------------------------------------------------
// srt_table: segment table storage
// Stores per entry the source base, the saturated inclusive source end and
// the target offset, with a valid bit per entry. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module srt_table #(
   parameter int TABLE_ENTRIES = 16,
   parameter int ADDR_BITS     = 32,
   parameter int IW            = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             wr_en,
   input  wire logic [srt_pkg::INDEX_BITS-1:0]   wr_idx,
   input  wire logic [ADDR_BITS-1:0]             wr_source,
   input  wire logic [ADDR_BITS-1:0]             wr_target,
   input  wire logic [ADDR_BITS-1:0]             wr_length,
   input  wire logic                             rd_en,
   input  wire logic [IW-1:0]                    rd_idx,
   output logic      [ADDR_BITS-1:0]             rd_start,
   output logic      [ADDR_BITS-1:0]             rd_end,
   output logic      [ADDR_BITS-1:0]             rd_offset,
   output logic                                  rd_nonzero
);
   import srt_pkg::*;

   logic [ADDR_BITS-1:0] start_mem  [TABLE_ENTRIES];
   logic [ADDR_BITS-1:0] end_mem    [TABLE_ENTRIES];
   logic [ADDR_BITS-1:0] offset_mem [TABLE_ENTRIES];
   logic                 nz_mem     [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   logic [ADDR_BITS:0]   sum_in;
   logic [ADDR_BITS-1:0] end_in;
   logic                 in_table;
   logic [IW-1:0]        waddr;

   // inclusive end, saturated at the top of the address space
   assign sum_in   = {1'b0, wr_source} + {1'b0, wr_length} - (ADDR_BITS+1)'(1);
   assign end_in   = sum_in[ADDR_BITS] ? {ADDR_BITS{1'b1}} : sum_in[ADDR_BITS-1:0];
   assign in_table = ({1'b0, wr_idx} < (INDEX_BITS+1)'(TABLE_ENTRIES));
   assign waddr    = IW'(wr_idx);

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en && in_table) begin
         start_mem[waddr]  <= wr_source;
         end_mem[waddr]    <= end_in;
         offset_mem[waddr] <= wr_target - wr_source;
         nz_mem[waddr]     <= (wr_length != '0);
      end
   end

   // track written entries
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && in_table) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   // registered read, unwritten entries cover nothing
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_start   <= start_mem[rd_idx];
         rd_end     <= end_mem[rd_idx];
         rd_offset  <= offset_mem[rd_idx];
         rd_nonzero <= nz_mem[rd_idx] && valid_ff[rd_idx];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/srt_sort_cell.sv */
// ----------------------------------------------------------------------------
// srt_sort_cell: one cell of the insertion sort chain
// Holds one covered span. On insert, the cell shifts right when empty or
// its key is above the new one; on pop, it takes its right neighbor's span.
// ----------------------------------------------------------------------------
`default_nettype none
module srt_sort_cell #(
   parameter int ADDR_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire srt_pkg::sort_cmd_type cmd,
   input  wire logic [ADDR_BITS-1:0]  key_lo,
   input  wire logic [ADDR_BITS-1:0]  key_hi,
   input  wire logic                  left_shift,
   input  wire logic                  left_valid,
   input  wire logic [ADDR_BITS-1:0]  left_lo,
   input  wire logic [ADDR_BITS-1:0]  left_hi,
   input  wire logic                  right_valid,
   input  wire logic [ADDR_BITS-1:0]  right_lo,
   input  wire logic [ADDR_BITS-1:0]  right_hi,
   output logic                       shift,
   output logic                       valid,
   output logic [ADDR_BITS-1:0]       lo,
   output logic [ADDR_BITS-1:0]       hi
);
   import srt_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ADDR_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;

   // stable order: equal keys keep their place ahead of the new one
   assign shift = !valid_ff || (lo_ff > key_lo);

   // choose the next span
   always_comb begin
      valid_in = valid_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.pop) begin
         valid_in = right_valid;
         lo_in    = right_lo;
         hi_in    = right_hi;
      end else if (cmd.insert && shift) begin
         if (left_shift) begin
            valid_in = left_valid;
            lo_in    = left_lo;
            hi_in    = left_hi;
         end else begin
            valid_in = 1'b1;
            lo_in    = key_lo;
            hi_in    = key_hi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign valid = valid_ff;
   assign lo    = lo_ff;
   assign hi    = hi_ff;

endmodule
`default_nettype wire
